// ===== design/ppa_pkg.sv =====
// Package for the partition placement allocator.
// Holds policy, function, register-index and state codes and the scan-token flag struct.
// No dependencies.
`default_nettype none

package ppa_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// fixed field widths
	localparam int SLOT_W      = 4;
	localparam int AMOUNT_W    = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;
	localparam int ACTIVE_W    = 5;
	localparam int POLICY_W    = 2;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd1;

	// item functions
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_REQ  = 1'b1;

	typedef enum logic [POLICY_W-1:0] {
		POL_WORST = 2'd0,
		POL_BEST  = 2'd1,
		POL_FIRST = 2'd2,
		POL_NEXT  = 2'd3
	} ppa_policy_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ppa_state_t;

	// flags of the search token that walks the cell chain
	// hit_a: candidate A found (the policy pick, or first fit overall for next fit)
	// hit_b: candidate B found (next fit only: first fit at or after the rover)
	typedef struct packed {
		logic valid;
		logic hit_a;
		logic hit_b;
	} ppa_flags_t;

endpackage

`default_nettype wire

// ===== design/ppa_if.sv =====
// Handshake channels of the partition placement allocator: request items in, result items out.
// Depends on ppa_pkg for the field widths.
`default_nettype none

interface ppa_in_if import ppa_pkg::*;;
	logic                valid;
	logic                ready;
	logic                func;
	logic [SLOT_W-1:0]   slot;
	logic [AMOUNT_W-1:0] amount;
	logic                last_request;

	modport source (output valid, func, slot, amount, last_request, input ready);
	modport sink   (input valid, func, slot, amount, last_request, output ready);
endinterface

interface ppa_out_if import ppa_pkg::*;;
	logic                valid;
	logic                ready;
	logic                granted;
	logic [SLOT_W-1:0]   chosen_slot;
	logic [AMOUNT_W-1:0] remaining;
	logic                batch_end;

	modport source (output valid, granted, chosen_slot, remaining, batch_end, input ready);
	modport sink   (input valid, granted, chosen_slot, remaining, batch_end, output ready);
endinterface

`default_nettype wire

// ===== design/ppa_cell.sv =====
// One partition cell: holds the partition's free size and refines the search token.
// Depends on ppa_pkg (policy codes, token flag struct).
`default_nettype none

module ppa_cell import ppa_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF,
	parameter int IDX        = 0,
	localparam int IDX_W     = $clog2(NUM_BLOCKS),
	localparam int CNT_W     = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ppa_policy_t          policy,
	input  wire logic [CNT_W-1:0]     cnt,
	input  wire logic [IDX_W-1:0]     start,
	input  wire logic [SIZE_BITS-1:0] req,
	input  wire logic                 wr_en,
	input  wire logic [SIZE_BITS-1:0] wr_data,
	input  wire ppa_flags_t           flags_i,
	input  wire logic [IDX_W-1:0]     a_idx_i,
	input  wire logic [SIZE_BITS-1:0] a_size_i,
	input  wire logic [IDX_W-1:0]     b_idx_i,
	input  wire logic [SIZE_BITS-1:0] b_size_i,
	output ppa_flags_t                flags_q,
	output logic [IDX_W-1:0]          a_idx_q,
	output logic [SIZE_BITS-1:0]      a_size_q,
	output logic [IDX_W-1:0]          b_idx_q,
	output logic [SIZE_BITS-1:0]      b_size_q
);

	logic [SIZE_BITS-1:0] free_q;
	logic                 active;
	logic                 fit;
	logic                 take_a;
	logic                 take_b;

	assign active = CNT_W'(IDX) < cnt;
	assign fit    = active && (free_q >= req);

	always_comb begin
		case (policy)
			POL_WORST: take_a = fit && (!flags_i.hit_a || (free_q > a_size_i));
			POL_BEST:  take_a = fit && (!flags_i.hit_a || (free_q < a_size_i));
			default:   take_a = fit && !flags_i.hit_a;
		endcase
	end

	assign take_b = (policy == POL_NEXT) && fit && !flags_i.hit_b && (IDX_W'(IDX) >= start);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (wr_en) begin
			free_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.valid <= flags_i.valid;
			flags_q.hit_a <= flags_i.hit_a | take_a;
			flags_q.hit_b <= flags_i.hit_b | take_b;
		end
	end

	always_ff @(posedge clk) begin
		a_idx_q  <= take_a ? IDX_W'(IDX) : a_idx_i;
		a_size_q <= take_a ? free_q : a_size_i;
		b_idx_q  <= take_b ? IDX_W'(IDX) : b_idx_i;
		b_size_q <= take_b ? free_q : b_size_i;
	end

endmodule

`default_nettype wire

// ===== design/partition_placement_allocator_top.sv =====
// Partition placement allocator: a load item is applied when it is accepted. A request's result
// is presented after the search, and the next item is taken once the block is idle again:
// the search token steps one partition cell per cycle, then a capture step and an update
// step follow; an earlier result still waiting in the output register holds the update.
// Reset clears all free sizes and the rover to zero, policy to worst fit, active_blocks to 16.
// Depends on ppa_pkg, ppa_in_if / ppa_out_if and ppa_cell.
`default_nettype none

module partition_placement_allocator_top import ppa_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	ppa_in_if.sink                     req,
	ppa_out_if.source                  rsp,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	// configuration registers
	ppa_policy_t         policy_q;
	logic [ACTIVE_W-1:0] active_q;

	// allocator state
	logic [IDX_W-1:0]     rover_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 last_q;
	ppa_state_t           state_q;
	ppa_state_t           state_nxt;

	// effective partition count and next fit start
	logic [CNT_W-1:0] cnt;
	logic [IDX_W-1:0] start;

	// token chain: element k feeds cell k, element NUM_BLOCKS is the chain end
	ppa_flags_t           flags_c  [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     a_idx_c  [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0] a_size_c [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     b_idx_c  [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0] b_size_c [NUM_BLOCKS+1];

	// captured search outcome
	logic                 fin_grant_q;
	logic [IDX_W-1:0]     fin_idx_q;
	logic [SIZE_BITS-1:0] fin_size_q;
	logic [SIZE_BITS-1:0] fin_rem;

	// output register
	logic                 rsp_valid_q;
	logic                 rsp_granted_q;
	logic [SLOT_W-1:0]    rsp_slot_q;
	logic [AMOUNT_W-1:0]  rsp_rem_q;
	logic                 rsp_end_q;

	// control strobes
	logic                 in_fire;
	logic                 inject;
	logic                 load;
	logic                 capture;
	logic                 finish;
	logic [SIZE_BITS-1:0] load_data;
	logic [SIZE_BITS-1:0] scan_req;

	// ---------------------------------------------------------------
	// Configuration: the user, not the block, must make writes arrive only while the block is idle
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_WORST;
			active_q <= ACTIVE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				CFG_POLICY: policy_q <= ppa_policy_t'(cfg_data[POLICY_W-1:0]);
				CFG_ACTIVE: active_q <= cfg_data[ACTIVE_W-1:0];
				default:    ;
			endcase
		end
	end

	// Clamp active_blocks to the table depth; a rover outside the active
	// range restarts the next fit search at partition zero.
	assign cnt   = (32'(active_q) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(active_q);
	assign start = (CNT_W'(rover_q) < cnt) ? rover_q : '0;

	// ---------------------------------------------------------------
	// Sequencer: idle -> scan (token walks the chain) -> done (update)
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (inject) state_nxt = ST_SCAN;
			ST_SCAN: if (flags_c[NUM_BLOCKS].valid) state_nxt = ST_DONE;
			ST_DONE: if (finish) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		in_fire   = req.valid && req.ready;
		inject    = in_fire && (req.func == FUNC_REQ);
		load      = in_fire && (req.func == FUNC_LOAD);
		capture   = (state_q == ST_SCAN) && flags_c[NUM_BLOCKS].valid;
		// hold the outcome until the output register can take it
		finish    = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);
	end

	// Latch the request size (cut to the table width) and the batch flag.
	always_ff @(posedge clk) begin
		if (inject) begin
			req_q  <= SIZE_BITS'(req.amount);
			last_q <= req.last_request;
		end
	end

	// ---------------------------------------------------------------
	// Cell chain: inject a fresh token into cell zero on a request
	// ---------------------------------------------------------------
	assign flags_c[0]  = '{valid: inject, hit_a: 1'b0, hit_b: 1'b0};
	assign a_idx_c[0]  = '0;
	assign a_size_c[0] = '0;
	assign b_idx_c[0]  = '0;
	assign b_size_c[0] = '0;

	assign load_data = SIZE_BITS'(req.amount);
	assign fin_rem   = fin_size_q - req_q;

	// cell zero checks on the accepting edge, before req_q holds the size
	assign scan_req  = inject ? load_data : req_q;

	for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
		logic                 wr_en;
		logic [SIZE_BITS-1:0] wr_data;

		// a load writes its slot; a grant writes back what is left
		assign wr_en   = (load && (32'(req.slot) == k))
			|| (finish && fin_grant_q && (32'(fin_idx_q) == k));
		assign wr_data = load ? load_data : fin_rem;

		ppa_cell #(
			.NUM_BLOCKS (NUM_BLOCKS),
			.SIZE_BITS  (SIZE_BITS),
			.IDX        (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.policy   (policy_q),
			.cnt      (cnt),
			.start    (start),
			.req      (scan_req),
			.wr_en    (wr_en),
			.wr_data  (wr_data),
			.flags_i  (flags_c[k]),
			.a_idx_i  (a_idx_c[k]),
			.a_size_i (a_size_c[k]),
			.b_idx_i  (b_idx_c[k]),
			.b_size_i (b_size_c[k]),
			.flags_q  (flags_c[k+1]),
			.a_idx_q  (a_idx_c[k+1]),
			.a_size_q (a_size_c[k+1]),
			.b_idx_q  (b_idx_c[k+1]),
			.b_size_q (b_size_c[k+1])
		);
	end

	// Take the token off the chain end. Next fit prefers a hit at or after
	// the rover and wraps to the first hit overall; B is only set for next fit.
	always_ff @(posedge clk) begin
		if (capture) begin
			fin_grant_q <= flags_c[NUM_BLOCKS].hit_a || flags_c[NUM_BLOCKS].hit_b;
			fin_idx_q   <= flags_c[NUM_BLOCKS].hit_b ? b_idx_c[NUM_BLOCKS]
				: a_idx_c[NUM_BLOCKS];
			fin_size_q  <= flags_c[NUM_BLOCKS].hit_b ? b_size_c[NUM_BLOCKS]
				: a_size_c[NUM_BLOCKS];
		end
	end

	// Advance the rover to every granted partition; leave it on a refusal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rover_q <= '0;
		end else if (finish && fin_grant_q) begin
			rover_q <= fin_idx_q;
		end
	end

	// ---------------------------------------------------------------
	// Output register: holds one result item until it is taken
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_granted_q <= fin_grant_q;
			rsp_slot_q    <= fin_grant_q ? SLOT_W'(fin_idx_q) : '0;
			rsp_rem_q     <= fin_grant_q ? AMOUNT_W'(fin_rem) : '0;
			rsp_end_q     <= last_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.granted     = rsp_granted_q;
	assign rsp.chosen_slot = rsp_slot_q;
	assign rsp.remaining   = rsp_rem_q;
	assign rsp.batch_end   = rsp_end_q;

endmodule

`default_nettype wire

// ===== tb/tb_partition_placement_allocator_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of partition_placement_allocator_top: directed and random load and
// request items under all four placement policies, checked against an in-bench allocator model.
// Depends on ppa_pkg, ppa_in_if / ppa_out_if and the allocator RTL.

module tb_partition_placement_allocator_top import ppa_pkg::*;;

	localparam int NUM_PARTS     = NUM_BLOCKS_DEF;
	// let a request's search and update finish, with room on top, before touching the registers
	localparam int SETTLE_CYCLES = NUM_PARTS + 8;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_ITEMS   = 86;
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct packed {
		logic                func;
		logic [SLOT_W-1:0]   slot;
		logic [AMOUNT_W-1:0] amount;
		logic                batch_last;
	} alloc_item_t;

	typedef struct packed {
		logic                granted;
		logic [SLOT_W-1:0]   chosen_slot;
		logic [AMOUNT_W-1:0] remaining;
		logic                batch_end;
	} grant_t;

	logic clk;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppa_in_if  req_ch ();
	ppa_out_if rsp_ch ();

	partition_placement_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// Allocator model state: free size table, roving pointer and the two registers.
	logic [AMOUNT_W-1:0] part_free [NUM_PARTS];
	logic [SLOT_W-1:0]   rover_q;
	ppa_policy_t         pol_q;
	logic [ACTIVE_W-1:0] active_q;

	alloc_item_t items_pending [$];   // items waiting for the driver
	grant_t      grants_due [$];      // results owed by the block, oldest first

	alloc_item_t cur_item;
	bit          drv_busy;            // cur_item is on the channel and not yet taken
	int          burst_left;
	int          gap_left;
	int unsigned sink_tick;

	int n_queued, n_loads, n_granted, n_refused, n_checked, n_settings, mismatches;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one accepted item to the model; return 1 and the result when it owes one.
	function automatic bit allocate_step(input alloc_item_t it, output grant_t g);
		int cnt;
		int pick;
		int idx;
		g = '0;
		if (it.func == FUNC_LOAD) begin
			part_free[it.slot] = it.amount;
			n_loads++;
			return 1'b0;
		end
		// an oversized active count is clipped to the table
		cnt = (active_q > ACTIVE_W'(NUM_PARTS)) ? NUM_PARTS : int'(active_q);
		pick = -1;
		if (pol_q == POL_NEXT) begin
			// start at the rover, or at zero when it lies beyond the active range; wrap once
			idx = (int'(rover_q) < cnt) ? int'(rover_q) : 0;
			for (int i = 0; i < cnt; i++) begin
				if (part_free[idx] >= it.amount) begin
					pick = idx;
					break;
				end
				idx = (idx + 1 == cnt) ? 0 : idx + 1;
			end
		end else begin
			for (int i = 0; i < cnt; i++) begin
				if (part_free[i] < it.amount)
					continue;
				// strict compares keep the lowest index on ties
				if (pick < 0)
					pick = i;
				else if (pol_q == POL_WORST && part_free[i] > part_free[pick])
					pick = i;
				else if (pol_q == POL_BEST && part_free[i] < part_free[pick])
					pick = i;
				if (pol_q == POL_FIRST)
					break;
			end
		end
		g.batch_end = it.batch_last;
		if (pick >= 0) begin
			part_free[pick] = part_free[pick] - it.amount;
			rover_q = SLOT_W'(pick);
			g.granted = 1'b1;
			g.chosen_slot = SLOT_W'(pick);
			g.remaining = part_free[pick];
			n_granted++;
		end else begin
			// refusal leaves the rover where it was
			n_refused++;
		end
		return 1'b1;
	endfunction

	// Mostly sizes that fit somewhere, with the extremes mixed in.
	function automatic logic [AMOUNT_W-1:0] pick_size(input bit for_load);
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			2, 3:    return AMOUNT_W'($urandom_range(0, 65535));
			4, 5, 6: return AMOUNT_W'($urandom_range(1, 300));
			default: return for_load ? AMOUNT_W'($urandom_range(1000, 65535))
			                         : AMOUNT_W'($urandom_range(1, 4000));
		endcase
	endfunction

	task automatic add_item(input logic func, input logic [SLOT_W-1:0] slot,
	                        input logic [AMOUNT_W-1:0] amount, input logic last);
		alloc_item_t it;
		it.func = func;
		it.slot = slot;
		it.amount = amount;
		it.batch_last = last;
		items_pending.push_back(it);
		n_queued++;
	endtask

	// Wait until every item is taken and every result is back, then let the block go quiet.
	task automatic drain();
		while (items_pending.size() != 0 || drv_busy || grants_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; the block is idle, so the model follows at once.
	task automatic set_config(input logic [CFG_DATA_W-1:0] pol_word,
	                          input logic [CFG_DATA_W-1:0] act);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= CFG_POLICY;
		cfg_data  <= pol_word;
		pol_q = ppa_policy_t'(pol_word[POLICY_W-1:0]);
		@(posedge clk);
		cfg_idx  <= CFG_ACTIVE;
		cfg_data <= act;
		active_q = act;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	// Sender: hold an item until taken, work in bursts with random gaps between them.
	always @(posedge clk) begin : drive_items
		grant_t due;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (allocate_step(cur_item, due))
					grants_due.push_back(due);
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (items_pending.size() != 0) begin
					cur_item = items_pending.pop_front();
					drv_busy = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						// about a quarter of the bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
					end
				end
				req_ch.valid        <= drv_busy;
				req_ch.func         <= cur_item.func;
				req_ch.slot         <= cur_item.slot;
				req_ch.amount       <= cur_item.amount;
				req_ch.last_request <= cur_item.batch_last;
			end
		end
	end

	// Receiver: check each taken result, then pick ready from a pattern that changes with bits 9:8
	// of the tick counter: always ready, one stall in four, coin flip, and long stalls.
	always @(posedge clk) begin : watch_results
		grant_t got;
		grant_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.granted     = rsp_ch.granted;
				got.chosen_slot = rsp_ch.chosen_slot;
				got.remaining   = rsp_ch.remaining;
				got.batch_end   = rsp_ch.batch_end;
				if (grants_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none owed: granted=%0b slot=%0d remaining=%0h batch_end=%0b",
						         $realtime, got.granted, got.chosen_slot, got.remaining, got.batch_end);
				end else begin
					want = grants_due.pop_front();
					n_checked++;
					if (got.granted !== want.granted || got.chosen_slot !== want.chosen_slot ||
					    got.remaining !== want.remaining || got.batch_end !== want.batch_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: expected granted=%0b slot=%0d remaining=%0h batch_end=%0b, got granted=%0b slot=%0d remaining=%0h batch_end=%0b",
							         $realtime, want.granted, want.chosen_slot, want.remaining,
							         want.batch_end, got.granted, got.chosen_slot, got.remaining,
							         got.batch_end);
					end
				end
			end
			sink_tick++;
			case (sink_tick[9:8])
				2'd0:    rsp_ch.ready <= 1'b1;
				2'd1:    rsp_ch.ready <= (sink_tick[1:0] != 2'd3);
				2'd2:    rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: rsp_ch.ready <= (sink_tick[4:0] < 5'd6);
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin : watchdog
		int unsigned cycles;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, grants_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int act_eff;
		int target;
		int nreq;
		logic [CFG_DATA_W-1:0] act;
		logic [SLOT_W-1:0] slot;

		// every block input known from time zero, reset held
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = CFG_POLICY;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_LOAD;
		req_ch.slot = '0;
		req_ch.amount = '0;
		req_ch.last_request = 1'b0;
		rsp_ch.ready = 1'b0;
		// model comes out of reset the same way the block does
		foreach (part_free[i])
			part_free[i] = '0;
		rover_q = '0;
		pol_q = POL_WORST;
		active_q = ACTIVE_RST;
		cur_item = '0;
		drv_busy = 1'b0;
		burst_left = 0;
		gap_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, reset settings first: worst fit over all sixteen partitions.
		// Zero request against an all-zero table ties everywhere and lands on slot 0.
		add_item(FUNC_REQ, 4'd0, 16'h0000, 1'b0);
		add_item(FUNC_REQ, 4'd7, 16'h0001, 1'b1);       // nothing free: refused
		add_item(FUNC_LOAD, 4'd0, 16'hFFFF, 1'b0);
		add_item(FUNC_LOAD, 4'd15, 16'h0001, 1'b1);
		add_item(FUNC_LOAD, 4'd5, 16'd100, 1'b0);
		add_item(FUNC_LOAD, 4'd6, 16'd100, 1'b0);
		add_item(FUNC_LOAD, 4'd9, 16'h8000, 1'b0);
		add_item(FUNC_REQ, 4'd15, 16'hFFFF, 1'b0);      // takes all of slot 0
		add_item(FUNC_REQ, 4'd0, 16'h0001, 1'b1);       // worst fit goes to slot 9
		drain();
		// best fit with a tie between slots 5 and 6, then the exact one-unit fit
		set_config({3'b000, POL_BEST}, 5'd16);
		add_item(FUNC_REQ, 4'd0, 16'd100, 1'b0);
		add_item(FUNC_REQ, 4'd0, 16'd1, 1'b1);
		drain();
		set_config({3'b000, POL_FIRST}, 5'd16);
		add_item(FUNC_REQ, 4'd0, 16'd50, 1'b1);
		drain();
		// next fit picks up at the partition first fit just used, then a refusal keeps the rover
		set_config({3'b000, POL_NEXT}, 5'd16);
		add_item(FUNC_REQ, 4'd0, 16'd10, 1'b0);
		add_item(FUNC_REQ, 4'd0, 16'h7000, 1'b0);
		add_item(FUNC_REQ, 4'd0, 16'hFFFF, 1'b1);
		add_item(FUNC_REQ, 4'd0, 16'h0000, 1'b0);
		drain();
		// shrink the active range below the rover: the search restarts at slot 0
		set_config({3'b000, POL_NEXT}, 5'd4);
		add_item(FUNC_LOAD, 4'd2, 16'd20, 1'b0);
		add_item(FUNC_REQ, 4'd0, 16'd5, 1'b1);
		drain();
		// no active partitions: even a zero request is refused
		set_config({3'b000, POL_WORST}, 5'd0);
		add_item(FUNC_REQ, 4'd0, 16'h0000, 1'b1);
		drain();
		// active count above the table size scans the whole table
		set_config({3'b111, POL_BEST}, 5'd31);
		add_item(FUNC_REQ, 4'd0, 16'd1, 1'b0);
		add_item(FUNC_LOAD, 4'd15, 16'hFFFF, 1'b0);
		add_item(FUNC_REQ, 4'd15, 16'hFFFF, 1'b1);

		// Random part: each phase sets a policy and active count, then runs batches of a few
		// loads followed by requests, with the last request flagged; one batch in ten is noise.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			case (ph)
				0:       act = 5'd16;
				1:       act = 5'd1;
				2:       act = 5'd0;
				3:       act = CFG_DATA_W'($urandom_range(17, 31));
				default: act = CFG_DATA_W'($urandom_range(1, 16));
			endcase
			act_eff = (act > 5'd16) ? 16 : int'(act);
			set_config({3'($urandom_range(0, 7)), 2'(ph % 4)}, act);
			target = n_queued + PHASE_ITEMS;
			while (n_queued < target) begin
				if ($urandom_range(0, 9) == 0) begin
					add_item(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 15)),
					         AMOUNT_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
				end else begin
					repeat ($urandom_range(0, 3)) begin
						// mostly refill partitions inside the active range
						if (act_eff > 0 && $urandom_range(0, 4) != 0)
							slot = SLOT_W'($urandom_range(0, act_eff - 1));
						else
							slot = SLOT_W'($urandom_range(0, 15));
						add_item(FUNC_LOAD, slot, pick_size(1'b1), 1'($urandom_range(0, 1)));
					end
					nreq = $urandom_range(1, 5);
					for (int k = 0; k < nreq; k++)
						add_item(FUNC_REQ, SLOT_W'($urandom_range(0, 15)), pick_size(1'b0),
						         k == nreq - 1);
				end
			end
		end
		drain();

		if (grants_due.size() != 0) begin
			mismatches += grants_due.size();
			$display("%0d results never arrived", grants_due.size());
		end
		$display("covered %0d items (%0d loads) over %0d register settings, all four policies",
		         n_queued, n_loads, n_settings);
		$display("checked %0d results: %0d granted, %0d refused; %0d mismatches",
		         n_checked, n_granted, n_refused, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
